@@ rtl/crnr_pkg.sv @@
package crnr_pkg;

   // parser state codes
   typedef logic [4:0] state_type;

   localparam state_type S_START    = 5'd0;
   localparam state_type S_A        = 5'd1;
   localparam state_type S_AS       = 5'd2;
   localparam state_type S_ASC      = 5'd3;
   localparam state_type S_ASCI     = 5'd4;
   localparam state_type S_I        = 5'd5;
   localparam state_type S_IS       = 5'd6;
   localparam state_type S_ISO      = 5'd7;
   localparam state_type S_ISO8     = 5'd8;
   localparam state_type S_ISO88    = 5'd9;
   localparam state_type S_ISO885   = 5'd10;
   localparam state_type S_ISO8859  = 5'd11;
   localparam state_type S_ISO8859D = 5'd12;
   localparam state_type S_L        = 5'd13;
   localparam state_type S_LA       = 5'd14;
   localparam state_type S_LAT      = 5'd15;
   localparam state_type S_LATI     = 5'd16;
   localparam state_type S_LATIN    = 5'd17;
   localparam state_type S_U        = 5'd18;
   localparam state_type S_UT       = 5'd19;
   localparam state_type S_UTF      = 5'd20;
   localparam state_type S_UTF1     = 5'd21;
   localparam state_type S_UTF16    = 5'd22;
   localparam state_type S_UTF16B   = 5'd23;
   localparam state_type S_UTF16L   = 5'd24;
   localparam state_type S_UTF3     = 5'd25;
   localparam state_type S_UTF32    = 5'd26;
   localparam state_type S_UTF32B   = 5'd27;
   localparam state_type S_UTF32L   = 5'd28;
   localparam state_type S_TAIL     = 5'd29;
   localparam state_type S_FAIL     = 5'd30;

   // charset codes
   typedef logic [3:0] code_type;

   localparam code_type CS_INVALID = 4'd0;
   localparam code_type CS_ASCII   = 4'd1;
   localparam code_type CS_LATIN1  = 4'd2;
   localparam code_type CS_UTF8    = 4'd3;
   localparam code_type CS_UTF16   = 4'd4;
   localparam code_type CS_UTF16LE = 4'd5;
   localparam code_type CS_UTF16BE = 4'd6;
   localparam code_type CS_UTF32   = 4'd7;
   localparam code_type CS_UTF32LE = 4'd8;
   localparam code_type CS_UTF32BE = 4'd9;

   typedef logic [7:0] char_type;

   // characters of interest
   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_LF    = 8'h0a;
   localparam char_type CH_CR    = 8'h0d;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_DASH  = "-";
   localparam char_type CH_1     = "1";
   localparam char_type CH_2     = "2";
   localparam char_type CH_3     = "3";
   localparam char_type CH_5     = "5";
   localparam char_type CH_6     = "6";
   localparam char_type CH_8     = "8";
   localparam char_type CH_9     = "9";
   localparam char_type CH_UA    = "A";
   localparam char_type CH_UZ    = "Z";
   localparam char_type CH_LA    = "a";
   localparam char_type CH_LB    = "b";
   localparam char_type CH_LC    = "c";
   localparam char_type CH_LE    = "e";
   localparam char_type CH_LF_   = "f";
   localparam char_type CH_LI    = "i";
   localparam char_type CH_LL    = "l";
   localparam char_type CH_LN    = "n";
   localparam char_type CH_LO    = "o";
   localparam char_type CH_LS    = "s";
   localparam char_type CH_LT    = "t";
   localparam char_type CH_LU    = "u";
   localparam char_type CASE_OFS = 8'd32;

   // one result word
   typedef struct packed {
      logic     done;
      code_type code;
      logic     failed;
   } result_type;

   function automatic char_type fold_case(input char_type c);
      return (c >= CH_UA && c <= CH_UZ) ? char_type'(c + CASE_OFS) : c;
   endfunction

   function automatic logic is_space(input char_type c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   // advance on a matching character, fail otherwise
   function automatic state_type match_next(input char_type c, input char_type ch,
                                            input state_type nxt);
      return (c == ch) ? nxt : S_FAIL;
   endfunction

   // trailing text: whitespace and end of string lead to the tail state
   function automatic state_type tail_next(input char_type c);
      return (c == CH_NUL || is_space(c)) ? S_TAIL : S_FAIL;
   endfunction

endpackage

@@ rtl/charset_name_recognizer_core.sv @@
// Channel  | Direction | Handshake          | Payload
// req      | in        | req_tvalid/tready  | tdata[7:0] = char_in
// rsp      | out       | rsp_tvalid/tready  | tdata[3:0] = charset_code, tlast = done_res,
//          |           |                    | tuser = failed
//
// One word in per cycle sustained while the result is not stalled; each result
// is offered after its byte has passed the input register and then the result
// register, set by the single parser transition between them. Reset clears
// both valid flags and returns the parser to its start state with no code
// found. A stalled result holds the result register and a full input register;
// req_tready drops only when both are full and the result is stalled.
module charset_name_recognizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] charset_code, [7:4] zero
   output logic       rsp_tlast,   // done_res
   output logic       rsp_tuser    // failed
);

   logic                 in_valid_ff;
   crnr_pkg::char_type   in_char_ff;
   logic                 out_valid_ff;
   crnr_pkg::result_type out_ff;
   crnr_pkg::result_type out_in;
   crnr_pkg::state_type  state_ff;
   crnr_pkg::state_type  state_in;
   crnr_pkg::code_type   code_ff;
   crnr_pkg::code_type   code_in;
   logic                 advance;

   // result register free to take a new word
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance || !in_valid_ff;

   crnr_step u_step (
      .state      (state_ff),
      .code       (code_ff),
      .c          (in_char_ff),
      .state_next (state_in),
      .code_next  (code_in),
      .result     (out_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   // parser state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= crnr_pkg::S_START;
         code_ff      <= crnr_pkg::CS_INVALID;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
            code_ff  <= code_in;
         end
      end
      if (advance && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.code};
   assign rsp_tlast  = out_ff.done;
   assign rsp_tuser  = out_ff.failed;

endmodule

@@ rtl/crnr_step.sv @@
module crnr_step (
   input  crnr_pkg::state_type  state,
   input  crnr_pkg::code_type   code,
   input  crnr_pkg::char_type   c,
   output crnr_pkg::state_type  state_next,
   output crnr_pkg::code_type   code_next,
   output crnr_pkg::result_type result
);

   crnr_pkg::char_type  l;
   crnr_pkg::state_type nx;
   crnr_pkg::code_type  cd;

   assign l = crnr_pkg::fold_case(c);

   // one transition of the name parser
   always_comb begin
      nx = crnr_pkg::S_FAIL;
      cd = code;
      unique case (state)
         crnr_pkg::S_START: begin
            if (crnr_pkg::is_space(c))   nx = crnr_pkg::S_START;
            else if (l == crnr_pkg::CH_LA) nx = crnr_pkg::S_A;
            else if (l == crnr_pkg::CH_LI) nx = crnr_pkg::S_I;
            else if (l == crnr_pkg::CH_LL) nx = crnr_pkg::S_L;
            else if (l == crnr_pkg::CH_LU) nx = crnr_pkg::S_U;
         end
         crnr_pkg::S_A:   nx = crnr_pkg::match_next(l, crnr_pkg::CH_LS, crnr_pkg::S_AS);
         crnr_pkg::S_AS:  nx = crnr_pkg::match_next(l, crnr_pkg::CH_LC, crnr_pkg::S_ASC);
         crnr_pkg::S_ASC: nx = crnr_pkg::match_next(l, crnr_pkg::CH_LI, crnr_pkg::S_ASCI);
         crnr_pkg::S_ASCI: begin
            if (l == crnr_pkg::CH_LI) begin
               nx = crnr_pkg::S_TAIL;
               cd = crnr_pkg::CS_ASCII;
            end
         end
         crnr_pkg::S_I:  nx = crnr_pkg::match_next(l, crnr_pkg::CH_LS, crnr_pkg::S_IS);
         crnr_pkg::S_IS: nx = crnr_pkg::match_next(l, crnr_pkg::CH_LO, crnr_pkg::S_ISO);
         crnr_pkg::S_ISO: begin
            if (c == crnr_pkg::CH_SPACE || c == crnr_pkg::CH_DASH) nx = crnr_pkg::S_ISO;
            else nx = crnr_pkg::match_next(c, crnr_pkg::CH_8, crnr_pkg::S_ISO8);
         end
         crnr_pkg::S_ISO8:
            nx = crnr_pkg::match_next(c, crnr_pkg::CH_8, crnr_pkg::S_ISO88);
         crnr_pkg::S_ISO88:
            nx = crnr_pkg::match_next(c, crnr_pkg::CH_5, crnr_pkg::S_ISO885);
         crnr_pkg::S_ISO885:
            nx = crnr_pkg::match_next(c, crnr_pkg::CH_9, crnr_pkg::S_ISO8859);
         crnr_pkg::S_ISO8859:
            nx = crnr_pkg::match_next(c, crnr_pkg::CH_DASH, crnr_pkg::S_ISO8859D);
         crnr_pkg::S_ISO8859D: begin
            if (c == crnr_pkg::CH_1) begin
               nx = crnr_pkg::S_TAIL;
               cd = crnr_pkg::CS_LATIN1;
            end
         end
         crnr_pkg::S_L:    nx = crnr_pkg::match_next(l, crnr_pkg::CH_LA, crnr_pkg::S_LA);
         crnr_pkg::S_LA:   nx = crnr_pkg::match_next(l, crnr_pkg::CH_LT, crnr_pkg::S_LAT);
         crnr_pkg::S_LAT:  nx = crnr_pkg::match_next(l, crnr_pkg::CH_LI, crnr_pkg::S_LATI);
         crnr_pkg::S_LATI: nx = crnr_pkg::match_next(l, crnr_pkg::CH_LN, crnr_pkg::S_LATIN);
         crnr_pkg::S_LATIN: begin
            if (c == crnr_pkg::CH_SPACE || c == crnr_pkg::CH_DASH) begin
               nx = crnr_pkg::S_LATIN;
            end else if (c == crnr_pkg::CH_1) begin
               nx = crnr_pkg::S_TAIL;
               cd = crnr_pkg::CS_LATIN1;
            end
         end
         crnr_pkg::S_U:  nx = crnr_pkg::match_next(l, crnr_pkg::CH_LT, crnr_pkg::S_UT);
         crnr_pkg::S_UT: nx = crnr_pkg::match_next(l, crnr_pkg::CH_LF_, crnr_pkg::S_UTF);
         crnr_pkg::S_UTF: begin
            if (c == crnr_pkg::CH_SPACE || c == crnr_pkg::CH_DASH) begin
               nx = crnr_pkg::S_UTF;
            end else if (c == crnr_pkg::CH_1) begin
               nx = crnr_pkg::S_UTF1;
            end else if (c == crnr_pkg::CH_3) begin
               nx = crnr_pkg::S_UTF3;
            end else if (c == crnr_pkg::CH_8) begin
               nx = crnr_pkg::S_TAIL;
               cd = crnr_pkg::CS_UTF8;
            end
         end
         crnr_pkg::S_UTF1: nx = crnr_pkg::match_next(c, crnr_pkg::CH_6, crnr_pkg::S_UTF16);
         crnr_pkg::S_UTF3: nx = crnr_pkg::match_next(c, crnr_pkg::CH_2, crnr_pkg::S_UTF32);
         // width without suffix: any other byte is checked as tail text and, if it passes, fixes the code
         crnr_pkg::S_UTF16, crnr_pkg::S_UTF32: begin
            if (c == crnr_pkg::CH_SPACE) begin
               nx = state;
            end else if (l == crnr_pkg::CH_LB) begin
               nx = (state == crnr_pkg::S_UTF16) ? crnr_pkg::S_UTF16B : crnr_pkg::S_UTF32B;
            end else if (l == crnr_pkg::CH_LL) begin
               nx = (state == crnr_pkg::S_UTF16) ? crnr_pkg::S_UTF16L : crnr_pkg::S_UTF32L;
            end else begin
               cd = (state == crnr_pkg::S_UTF16) ? crnr_pkg::CS_UTF16 : crnr_pkg::CS_UTF32;
               nx = crnr_pkg::tail_next(c);
            end
         end
         crnr_pkg::S_UTF16L, crnr_pkg::S_UTF16B,
         crnr_pkg::S_UTF32L, crnr_pkg::S_UTF32B: begin
            if (l == crnr_pkg::CH_LE) begin
               nx = crnr_pkg::S_TAIL;
               if (state == crnr_pkg::S_UTF16L)      cd = crnr_pkg::CS_UTF16LE;
               else if (state == crnr_pkg::S_UTF16B) cd = crnr_pkg::CS_UTF16BE;
               else if (state == crnr_pkg::S_UTF32L) cd = crnr_pkg::CS_UTF32LE;
               else                                  cd = crnr_pkg::CS_UTF32BE;
            end
         end
         crnr_pkg::S_TAIL: nx = crnr_pkg::tail_next(c);
         default:          nx = crnr_pkg::S_FAIL;
      endcase
      if (nx == crnr_pkg::S_FAIL) cd = crnr_pkg::CS_INVALID;
   end

   // result word and the state left behind; end of string restarts the parser
   always_comb begin
      result.done   = (c == crnr_pkg::CH_NUL);
      result.code   = cd;
      result.failed = (nx == crnr_pkg::S_FAIL);
      if (c == crnr_pkg::CH_NUL) begin
         state_next = crnr_pkg::S_START;
         code_next  = crnr_pkg::CS_INVALID;
      end else begin
         state_next = nx;
         code_next  = cd;
      end
   end

endmodule

@@ rtl/crnr_checker.sv @@
module crnr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // a failed name never carries a code
   a_fail_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[3:0] == 4'd0)
      else $error("failed result with nonzero code");

   // code is in range and the padding is zero
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'd0 && rsp_tdata[3:0] <= 4'd9)
      else $error("charset code out of range");

   // input is never stalled while the result register is empty
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind charset_name_recognizer_core crnr_checker u_crnr_checker (.*);
